// ===== rtl/sqct_pkg.sv =====
// ----------------------------------------------------------------------------
// sqct_pkg
// Types and constants shared by the sprite quad corner transform unit.
// ----------------------------------------------------------------------------
package sqct_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_ZOOM         = 3'd1,
    REG_QUAD_SIZE    = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4,
    REG_SCREEN_OFF_X = 3'd5,
    REG_SCREEN_OFF_Y = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] local_x;
    logic signed [15:0] local_y;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [15:0] pre_x;
    logic signed [15:0] pre_y;
    logic signed [15:0] scr_x;
    logic signed [15:0] scr_y;
    logic               scr_valid;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        zoom;
    logic [15:0]        quad_size;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] screen_off_x;
    logic signed [15:0] screen_off_y;
  } cfg_t;

  typedef struct packed {
    in_beat_t   item;
    logic [1:0] corner;
  } corner_beat_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic               mode;
    logic signed [15:0] pre_x;
    logic signed [15:0] pre_y;
    logic signed [15:0] scr_x;
    logic signed [15:0] scr_y;
    logic               scr_valid;
  } geom_beat_t;

endpackage

// ===== rtl/sqct_expand.sv =====
// ----------------------------------------------------------------------------
// sqct_expand
// Holds one sprite and issues its four corner beats, one per cycle while dn_stall is low.
// ----------------------------------------------------------------------------
module sqct_expand import sqct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_beat_t     in_beat,
  output logic         dn_valid,
  input  logic         dn_stall,
  output corner_beat_t dn_beat
);

  logic       vld_r, vld_nxt;
  logic [1:0] k_r, k_nxt;
  in_beat_t   item_r;
  logic       step;
  logic       take;

  assign step     = vld_r && !dn_stall;
  assign in_stall = vld_r && !(step && (k_r == CORNER_LAST));
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    k_nxt   = k_r;
    if (take) begin
      vld_nxt = 1'b1;
      k_nxt   = CORNER_FIRST;
    end else if (step) begin
      if (k_r == CORNER_LAST) begin
        vld_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= CORNER_FIRST;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_beat;
    end
  end

  assign dn_valid       = vld_r;
  assign dn_beat.item   = item_r;
  assign dn_beat.corner = k_r;

endmodule

// ===== rtl/sqct_geom.sv =====
// ----------------------------------------------------------------------------
// sqct_geom
// Three-stage corner geometry: corner vector, products, rotate or center.
// ----------------------------------------------------------------------------
module sqct_geom import sqct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         up_valid,
  output logic         up_stall,
  input  corner_beat_t up_beat,
  output logic         dn_valid,
  input  logic         dn_stall,
  output geom_beat_t   dn_beat
);

  logic en1, en2, en3;

  // stage 1
  logic               g1_vld_r;
  logic [1:0]         g1_k_r;
  logic               g1_mode_r;
  logic signed [17:0] g1_vx_r, g1_vx_nxt;
  logic signed [17:0] g1_vy_r, g1_vy_nxt;
  logic signed [15:0] g1_mx_r, g1_my_r;
  logic signed [15:0] g1_sn_r, g1_cs_r;

  // stage 2
  logic               g2_vld_r;
  logic [1:0]         g2_k_r;
  logic               g2_mode_r;
  logic signed [34:0] g2_p0_r, g2_p1_r, g2_p2_r, g2_p3_r;
  logic signed [15:0] g2_mx_r, g2_my_r;
  logic signed [15:0] g2_prex_r, g2_prex_nxt;
  logic signed [15:0] g2_prey_r, g2_prey_nxt;

  // stage 3
  logic       g3_vld_r;
  geom_beat_t g3_beat_r, g3_beat_nxt;

  logic signed [17:0] px18, py18, lx18, ly18, ox18, oy18, half18, size18;
  logic signed [16:0] mul_b, sn17;
  logic signed [15:0] half16;
  logic signed [34:0] rot_x, rot_y;
  logic signed [15:0] tx, ty, dz;

  assign en3      = !g3_vld_r || !dn_stall;
  assign en2      = !g2_vld_r || en3;
  assign en1      = !g1_vld_r || en2;
  assign up_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
      g3_vld_r <= 1'b0;
    end else begin
      if (en1) begin
        g1_vld_r <= up_valid;
      end
      if (en2) begin
        g2_vld_r <= g1_vld_r;
      end
      if (en3) begin
        g3_vld_r <= g2_vld_r;
      end
    end
  end

  assign px18   = {{2{up_beat.item.pos_x[15]}}, up_beat.item.pos_x};
  assign py18   = {{2{up_beat.item.pos_y[15]}}, up_beat.item.pos_y};
  assign lx18   = {{2{up_beat.item.local_x[15]}}, up_beat.item.local_x};
  assign ly18   = {{2{up_beat.item.local_y[15]}}, up_beat.item.local_y};
  assign ox18   = {{2{cfg.origin_x[15]}}, cfg.origin_x};
  assign oy18   = {{2{cfg.origin_y[15]}}, cfg.origin_y};
  assign half18 = {3'b000, cfg.quad_size[15:1]};
  assign size18 = {2'b00, cfg.quad_size};

  always_comb begin
    if (cfg.mode) begin
      g1_vx_nxt = lx18 - half18 + (up_beat.corner[0] ? size18 : 18'sd0);
      g1_vy_nxt = ly18 - half18 + (up_beat.corner[1] ? size18 : 18'sd0);
    end else begin
      g1_vx_nxt = px18 + lx18 - ox18;
      g1_vy_nxt = py18 + ly18 - oy18;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      g1_k_r    <= up_beat.corner;
      g1_mode_r <= cfg.mode;
      g1_vx_r   <= g1_vx_nxt;
      g1_vy_r   <= g1_vy_nxt;
      g1_mx_r   <= up_beat.item.pos_x - cfg.origin_x;
      g1_my_r   <= up_beat.item.pos_y - cfg.origin_y;
      g1_sn_r   <= up_beat.item.sine;
      g1_cs_r   <= up_beat.item.cosine;
    end
  end

  assign mul_b  = g1_mode_r ? {g1_cs_r[15], g1_cs_r} : {1'b0, cfg.zoom};
  assign sn17   = {g1_sn_r[15], g1_sn_r};
  assign half16 = {1'b0, cfg.quad_size[15:1]};

  always_comb begin
    g2_prex_nxt = g1_k_r[0] ? g1_vx_r[15:0] + half16 : g1_vx_r[15:0] - half16;
    g2_prey_nxt = g1_k_r[1] ? g1_vy_r[15:0] + half16 : g1_vy_r[15:0] - half16;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      g2_k_r    <= g1_k_r;
      g2_mode_r <= g1_mode_r;
      g2_p0_r   <= g1_vx_r * mul_b;
      g2_p1_r   <= g1_vy_r * mul_b;
      g2_p2_r   <= g1_vx_r * sn17;
      g2_p3_r   <= g1_vy_r * sn17;
      g2_mx_r   <= g1_mx_r;
      g2_my_r   <= g1_my_r;
      g2_prex_r <= g2_prex_nxt;
      g2_prey_r <= g2_prey_nxt;
    end
  end

  assign rot_x = g2_p0_r - g2_p3_r;
  assign rot_y = g2_p2_r + g2_p1_r;
  assign tx    = g2_p0_r[29:14] + cfg.screen_off_x;
  assign ty    = g2_p1_r[29:14] + cfg.screen_off_y;
  assign dz    = {7'b0000000, cfg.zoom[15:7]};

  always_comb begin
    g3_beat_nxt.corner    = g2_k_r;
    g3_beat_nxt.mode      = g2_mode_r;
    g3_beat_nxt.scr_x     = '0;
    g3_beat_nxt.scr_y     = '0;
    g3_beat_nxt.scr_valid = 1'b1;
    if (g2_mode_r) begin
      g3_beat_nxt.pre_x = rot_x[30:15] + g2_mx_r;
      g3_beat_nxt.pre_y = rot_y[30:15] + g2_my_r;
    end else begin
      g3_beat_nxt.pre_x = g2_prex_r;
      g3_beat_nxt.pre_y = g2_prey_r;
      case (g2_k_r)
        CORNER_FIRST: begin
          g3_beat_nxt.scr_x = tx - dz;
          g3_beat_nxt.scr_y = ty - dz;
        end
        CORNER_LAST: begin
          g3_beat_nxt.scr_x = tx + dz;
          g3_beat_nxt.scr_y = ty + dz;
        end
        default: begin
          g3_beat_nxt.scr_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      g3_beat_r <= g3_beat_nxt;
    end
  end

  assign dn_valid = g3_vld_r;
  assign dn_beat  = g3_beat_r;

endmodule

// ===== rtl/sqct_view.sv =====
// ----------------------------------------------------------------------------
// sqct_view
// Two-stage viewport scaling of rotated corners, ending in the result register.
// ----------------------------------------------------------------------------
module sqct_view import sqct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       up_valid,
  output logic       up_stall,
  input  geom_beat_t up_beat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat
);

  logic en1, en2;

  logic               v1_vld_r;
  geom_beat_t         v1_beat_r;
  logic signed [32:0] v1_px_r, v1_py_r;
  logic signed [16:0] zoom17;

  logic      v2_vld_r;
  out_beat_t v2_beat_r, v2_beat_nxt;

  assign en2      = !v2_vld_r || !out_stall;
  assign en1      = !v1_vld_r || en2;
  assign up_stall = !en1;
  assign zoom17   = {1'b0, cfg.zoom};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
      v2_vld_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_vld_r <= up_valid;
      end
      if (en2) begin
        v2_vld_r <= v1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      v1_beat_r <= up_beat;
      v1_px_r   <= up_beat.pre_x * zoom17;
      v1_py_r   <= up_beat.pre_y * zoom17;
    end
  end

  always_comb begin
    v2_beat_nxt.corner    = v1_beat_r.corner;
    v2_beat_nxt.pre_x     = v1_beat_r.pre_x;
    v2_beat_nxt.pre_y     = v1_beat_r.pre_y;
    v2_beat_nxt.scr_valid = v1_beat_r.scr_valid;
    v2_beat_nxt.last      = (v1_beat_r.corner == CORNER_LAST);
    if (v1_beat_r.mode) begin
      v2_beat_nxt.scr_x = v1_px_r[29:14] + cfg.screen_off_x;
      v2_beat_nxt.scr_y = v1_py_r[29:14] + cfg.screen_off_y;
    end else begin
      v2_beat_nxt.scr_x = v1_beat_r.scr_x;
      v2_beat_nxt.scr_y = v1_beat_r.scr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      v2_beat_r <= v2_beat_nxt;
    end
  end

  assign out_valid = v2_vld_r;
  assign out_beat  = v2_beat_r;

endmodule

// ===== rtl/sprite_quad_corner_transform_unit.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_corner_transform_unit
// Turns one sprite beat into four screen-space quad corner beats.
//
// Input channel (in_valid, in_stall, in_beat): one sprite per beat, carrying
// position, local offset and Q15 sine and cosine. Result channel (out_valid,
// out_stall, out_beat): corners 0, 1, 2, 3 of each sprite in order, with
// last set on corner 3. Configuration port (cfg_we, cfg_idx, cfg_wdata):
// write-only registers; write them only while no sprite is in flight.
// Throughput: one corner per cycle while out_stall is low; the single
// result channel sets that rate. A sprite is taken while the previous
// one issues its last corner, so sprites stream without gaps. Corner 0
// of a taken sprite beat passes through a corner issue register, three
// geometry stages and two viewport stages. Stages are individually
// enabled, so bubbles are squeezed out.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults. When out_stall is high the result holds and the stages
// behind it fill up before in_stall rises.
// ----------------------------------------------------------------------------
module sprite_quad_corner_transform_unit import sqct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  logic         cb_valid, cb_stall;
  corner_beat_t cb_beat;
  logic         gb_valid, gb_stall;
  geom_beat_t   gb_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= 1'b0;
      cfg_r.zoom         <= 16'd256;
      cfg_r.quad_size    <= 16'd256;
      cfg_r.origin_x     <= 16'sd1280;
      cfg_r.origin_y     <= 16'sd2560;
      cfg_r.screen_off_x <= 16'sd22;
      cfg_r.screen_off_y <= 16'sd42;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:         cfg_r.mode         <= cfg_wdata[0];
        REG_ZOOM:         cfg_r.zoom         <= cfg_wdata;
        REG_QUAD_SIZE:    cfg_r.quad_size    <= cfg_wdata;
        REG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        REG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        REG_SCREEN_OFF_X: cfg_r.screen_off_x <= cfg_wdata;
        REG_SCREEN_OFF_Y: cfg_r.screen_off_y <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sqct_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .dn_valid (cb_valid),
    .dn_stall (cb_stall),
    .dn_beat  (cb_beat)
  );

  sqct_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (cb_valid),
    .up_stall (cb_stall),
    .up_beat  (cb_beat),
    .dn_valid (gb_valid),
    .dn_stall (gb_stall),
    .dn_beat  (gb_beat)
  );

  sqct_view u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (gb_valid),
    .up_stall  (gb_stall),
    .up_beat   (gb_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ===== rtl/sqct_checker.sv =====
// ----------------------------------------------------------------------------
// sqct_checker
// Port-level checks of the sprite quad corner transform unit.
// ----------------------------------------------------------------------------
module sqct_checker import sqct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed");

  a_item_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sprite taken while previous one still issues corners");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.last == (out_beat.corner == CORNER_LAST)))
    else $error("last flag does not match corner index");

  a_outer_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.corner == CORNER_FIRST || out_beat.corner == CORNER_LAST)
      |-> out_beat.scr_valid)
    else $error("outer corner without screen coordinates");

  a_blank_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.scr_valid |-> out_beat.scr_x == 16'sd0 && out_beat.scr_y == 16'sd0)
    else $error("screen coordinates not cleared on unscaled corner");

endmodule

bind sprite_quad_corner_transform_unit sqct_checker u_sqct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
